@@ design/bbd_pkg.sv @@
`timescale 1ns / 1ps

package bbd_pkg;

   localparam int PIXEL_W           = 8;
   localparam int CFG_W             = 13;
   localparam int CSR_INDEX_W       = 2;
   localparam int IN_ROW_W          = 13;
   localparam int OUT_ROW_W         = 12;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int IN_ROW_MAX        = 8191;
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;
   localparam int SUM_W             = 10;
   localparam int CNT_W             = 3;
   localparam int RECIP3            = 683;
   localparam int RECIP3_SHIFT      = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_GREEN_FIRST  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SITE_RED   = 2'd0,
      SITE_GREEN = 2'd1,
      SITE_BLUE  = 2'd2
   } colour_type;

   typedef struct packed {
      colour_type colour;
      logic       row_odd;
      logic       up;
      logic       dn;
      logic       lf;
      logic       rt;
   } site_type;

endpackage

@@ design/bbd_stream_if.sv @@
`timescale 1ns / 1ps

interface bbd_req_if;
   import bbd_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] raw_pixel;
   logic               pad;

   modport source (output valid, output raw_pixel, output pad, input ready);
   modport sink (input valid, input raw_pixel, input pad, output ready);
endinterface

interface bbd_rsp_if;
   import bbd_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] red;
   logic [PIXEL_W-1:0] green;
   logic [PIXEL_W-1:0] blue;
   logic               frame_end;

   modport source (output valid, output red, output green, output blue, output frame_end,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input frame_end,
                 output ready);
endinterface

@@ design/bbd_line_mem.sv @@
`timescale 1ns / 1ps

module bbd_line_mem #(
   parameter int DEPTH  = bbd_pkg::DEFAULT_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 2 * bbd_pkg::PIXEL_W
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bbd_interp.sv @@
`timescale 1ns / 1ps

module bbd_interp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [bbd_pkg::PIXEL_W-1:0] top,
   input  logic [bbd_pkg::PIXEL_W-1:0] mid,
   input  logic [bbd_pkg::PIXEL_W-1:0] sample,
   input  logic                        sum_en,
   input  bbd_pkg::site_type           site,
   output logic [bbd_pkg::PIXEL_W-1:0] red,
   output logic [bbd_pkg::PIXEL_W-1:0] green,
   output logic [bbd_pkg::PIXEL_W-1:0] blue
);
   import bbd_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
   } chan_type;

   logic [PIXEL_W-1:0] win_ff [9];
   chan_type           red_ff, green_ff, blue_ff;
   chan_type           red_in, green_in, blue_in;
   chan_type           nbr, diag, horiz, vert, center;

   function automatic logic [SUM_W-1:0] tap(input logic [PIXEL_W-1:0] value, input logic use_it);
      tap = use_it ? SUM_W'(value) : '0;
   endfunction

   function automatic logic [PIXEL_W-1:0] mean(input chan_type ch);
      logic [2*SUM_W-1:0] prod;
      prod = (2*SUM_W)'(ch.sum) * (2*SUM_W)'(RECIP3);
      unique case (ch.cnt)
         CNT_W'(1): mean = ch.sum[PIXEL_W-1:0];
         CNT_W'(2): mean = ch.sum[PIXEL_W:1];
         CNT_W'(3): mean = prod[RECIP3_SHIFT +: PIXEL_W];
         CNT_W'(4): mean = ch.sum[PIXEL_W+1:2];
         default:   mean = '0;
      endcase
   endfunction

   // 3x3 window, row 0 on top, column 2 newest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3 + 1];
            win_ff[k*3 + 1] <= win_ff[k*3 + 2];
         end
         win_ff[2] <= top;
         win_ff[5] <= mid;
         win_ff[8] <= sample;
      end
   end

   always_comb begin
      nbr.sum   = tap(win_ff[1], site.up) + tap(win_ff[7], site.dn)
                + tap(win_ff[3], site.lf) + tap(win_ff[5], site.rt);
      nbr.cnt   = CNT_W'(site.up) + CNT_W'(site.dn) + CNT_W'(site.lf) + CNT_W'(site.rt);
      diag.sum  = tap(win_ff[0], site.up & site.lf) + tap(win_ff[2], site.up & site.rt)
                + tap(win_ff[6], site.dn & site.lf) + tap(win_ff[8], site.dn & site.rt);
      diag.cnt  = CNT_W'(site.up & site.lf) + CNT_W'(site.up & site.rt)
                + CNT_W'(site.dn & site.lf) + CNT_W'(site.dn & site.rt);
      horiz.sum = tap(win_ff[3], site.lf) + tap(win_ff[5], site.rt);
      horiz.cnt = CNT_W'(site.lf) + CNT_W'(site.rt);
      vert.sum  = tap(win_ff[1], site.up) + tap(win_ff[7], site.dn);
      vert.cnt  = CNT_W'(site.up) + CNT_W'(site.dn);
      center.sum = SUM_W'(win_ff[4]);
      center.cnt = CNT_W'(1);

      unique case (site.colour)
         SITE_GREEN: begin
            green_in = center;
            if (site.row_odd) begin
               red_in  = vert;
               blue_in = horiz;
            end else begin
               red_in  = horiz;
               blue_in = vert;
            end
         end
         SITE_RED: begin
            red_in   = center;
            green_in = nbr;
            blue_in  = diag;
         end
         default: begin
            blue_in  = center;
            green_in = nbr;
            red_in   = diag;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = mean(red_ff);
   assign green = mean(green_ff);
   assign blue  = mean(blue_ff);

endmodule

@@ design/bayer_bilinear_demosaic.sv @@
`timescale 1ns / 1ps

// Bilinear Bayer demosaic of a raw pixel stream.
// req_if takes one raw sample per beat in raster order; pad marks the
// frame_width+1 drain beats the source sends after each frame (value taken as 0).
// rsp_if gives one RGB beat per pixel site, frame_end on the last pixel.
// csr_* writes frame_width, frame_height and green_first; write only while idle.
// Output trails input by one row plus one pixel: the beat that completes a
// pixel's 3x3 neighborhood produces that pixel.
// Each beat does a read-modify-write of the two-row line memory at its column:
// a beat with no result passes the accept and memory read steps, a beat with a
// result also the neighbor sums step and the mean and output register step.
// The output register frees the input side: a finished pixel may wait while
// the next beat is taken; a beat with a result holds in its last step until
// the waiting pixel is taken.
// Reset is synchronous: counters, state, window, configuration and result-valid
// registers return to defaults (640x480, RGGB). The line memory is not cleared;
// unwritten entries only feed neighbors outside the frame.
module bayer_bilinear_demosaic #(
   parameter int MAX_WIDTH = bbd_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   bbd_req_if.sink                         req_if,
   bbd_rsp_if.source                       rsp_if,
   input  logic                            csr_write,
   input  logic [bbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bbd_pkg::CFG_W-1:0]       csr_data
);
   import bbd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int W_W   = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (W_W > CFG_W) ? W_W : CFG_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      width_ff, height_ff;
   logic                  green_first_ff;
   logic [COL_W-1:0]      in_column_ff, in_column_in;
   logic [IN_ROW_W-1:0]   in_row_ff, in_row_in;
   logic [COL_W-1:0]      out_column_ff, out_column_in;
   logic [OUT_ROW_W-1:0]  out_row_ff, out_row_in;
   logic [PIXEL_W-1:0]    sample_ff;
   logic [COL_W-1:0]      addr_ff;
   logic                  emit_ff;
   logic                  fe_ff;
   site_type              site_ff, site_in;
   logic                  rsp_valid_ff;
   logic [PIXEL_W-1:0]    red_ff, green_ff, blue_ff;
   logic                  frame_end_ff;

   logic [CMP_W-1:0]      eff_w, fw_ext, col_plus;
   logic [CFG_W-1:0]      eff_h;
   logic                  accept, load_out;
   logic                  col_over, last_col_in, emit, fe;
   logic [COL_W-1:0]      col_cur;
   logic [IN_ROW_W-1:0]   row_cur;
   logic [2*PIXEL_W-1:0]  rd_data;
   logic [PIXEL_W-1:0]    red_c, green_c, blue_c;

   function automatic logic [IN_ROW_W-1:0] row_step(input logic [IN_ROW_W-1:0] r);
      row_step = (r == IN_ROW_W'(IN_ROW_MAX)) ? r : r + 1'b1;
   endfunction

   assign accept   = req_if.valid && req_if.ready;
   assign load_out = (state_ff == ST_DIV) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (state_ff == ST_IDLE);

   // clamped geometry
   always_comb begin
      fw_ext = CMP_W'(width_ff);
      if (fw_ext == '0) begin
         eff_w = CMP_W'(1);
      end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
         eff_w = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      if (height_ff == '0) begin
         eff_h = CFG_W'(1);
      end else if (height_ff > CFG_W'(HEIGHT_LIMIT)) begin
         eff_h = CFG_W'(HEIGHT_LIMIT);
      end else begin
         eff_h = height_ff;
      end
   end

   // position bookkeeping for the beat being accepted
   always_comb begin
      col_over    = CMP_W'(in_column_ff) >= eff_w;
      col_cur     = col_over ? '0 : in_column_ff;
      row_cur     = col_over ? row_step(in_row_ff) : in_row_ff;
      emit        = (row_cur >= IN_ROW_W'(2)) || ((row_cur == IN_ROW_W'(1)) && (col_cur != '0));
      col_plus    = CMP_W'(col_cur) + CMP_W'(1);
      last_col_in = col_plus >= eff_w;

      site_in.up      = out_row_ff != '0;
      site_in.dn      = (CFG_W'(out_row_ff) + CFG_W'(1)) < eff_h;
      site_in.lf      = out_column_ff != '0;
      site_in.rt      = (CMP_W'(out_column_ff) + CMP_W'(1)) < eff_w;
      site_in.row_odd = out_row_ff[0];
      if (out_row_ff[0]) begin
         site_in.colour = (out_column_ff[0] ^ green_first_ff) ? SITE_BLUE : SITE_GREEN;
      end else begin
         site_in.colour = (out_column_ff[0] ^ green_first_ff) ? SITE_GREEN : SITE_RED;
      end
      fe = !site_in.dn && !site_in.rt;

      if (last_col_in) begin
         in_column_in = '0;
         in_row_in    = row_step(row_cur);
      end else begin
         in_column_in = col_plus[COL_W-1:0];
         in_row_in    = row_cur;
      end
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (emit) begin
         priority if (fe) begin
            in_column_in  = '0;
            in_row_in     = '0;
            out_column_in = '0;
            out_row_in    = '0;
         end else if (!site_in.rt) begin
            out_column_in = '0;
            out_row_in    = out_row_ff + 1'b1;
         end else begin
            out_column_in = out_column_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = emit_ff ? ST_SUM : ST_IDLE;
         ST_SUM:  state_in = ST_DIV;
         ST_DIV:  if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         width_ff       <= CFG_W'(WIDTH_RESET);
         height_ff      <= CFG_W'(HEIGHT_RESET);
         green_first_ff <= 1'b0;
         in_column_ff   <= '0;
         in_row_ff      <= '0;
         out_column_ff  <= '0;
         out_row_ff     <= '0;
         emit_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_ff <= csr_data;
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_ff <= csr_data;
            end else if (csr_index == CSR_GREEN_FIRST) begin
               green_first_ff <= csr_data[0];
            end
         end
         if (accept) begin
            in_column_ff  <= in_column_in;
            in_row_ff     <= in_row_in;
            out_column_ff <= out_column_in;
            out_row_ff    <= out_row_in;
            emit_ff       <= emit;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_if.pad ? '0 : req_if.raw_pixel;
         addr_ff   <= col_cur;
         site_ff   <= site_in;
         fe_ff     <= fe;
      end
      if (load_out) begin
         red_ff       <= red_c;
         green_ff     <= green_c;
         blue_ff      <= blue_c;
         frame_end_ff <= fe_ff;
      end
   end

   // upper byte: two rows back, lower byte: previous row
   bbd_line_mem #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W),
      .DATA_W(2 * PIXEL_W)
   ) u_line_mem (
      .clock  (clock),
      .rd_en  (accept),
      .rd_addr(col_cur),
      .rd_data(rd_data),
      .wr_en  (state_ff == ST_READ),
      .wr_addr(addr_ff),
      .wr_data({rd_data[PIXEL_W-1:0], sample_ff})
   );

   bbd_interp u_interp (
      .clock   (clock),
      .reset   (reset),
      .shift_en(state_ff == ST_READ),
      .top     (rd_data[2*PIXEL_W-1:PIXEL_W]),
      .mid     (rd_data[PIXEL_W-1:0]),
      .sample  (sample_ff),
      .sum_en  (state_ff == ST_SUM),
      .site    (site_ff),
      .red     (red_c),
      .green   (green_c),
      .blue    (blue_c)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.red       = red_ff;
   assign rsp_if.green     = green_ff;
   assign rsp_if.blue      = blue_ff;
   assign rsp_if.frame_end = frame_end_ff;

endmodule

@@ design/bbd_checker.sv @@
`timescale 1ns / 1ps

module bbd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bbd_pkg::PIXEL_W-1:0] rsp_red,
   input logic [bbd_pkg::PIXEL_W-1:0] rsp_green,
   input logic [bbd_pkg::PIXEL_W-1:0] rsp_blue,
   input logic                        rsp_frame_end
);

   // one beat in flight at a time
   property p_busy_after_accept;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready) |=> !req_ready;
   endproperty
   a_busy_after_accept: assert property (p_busy_after_accept)
      else $error("input taken again right after a beat");

   property p_no_rsp_after_reset;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_no_rsp_after_reset: assert property (p_no_rsp_after_reset)
      else $error("result valid right after reset");

   property p_rsp_held;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
            && $stable(rsp_blue) && $stable(rsp_frame_end);
   endproperty
   a_rsp_held: assert property (p_rsp_held)
      else $error("stalled result changed or dropped");

   // a new result needs its beat to have passed the read and sum steps first
   property p_rsp_needs_beat;
      @(posedge clock) disable iff (reset)
         ($rose(rsp_valid) || (rsp_valid && $past(rsp_valid && rsp_ready)))
            |-> !$past(req_valid && req_ready, 1) && !$past(req_valid && req_ready, 2);
   endproperty
   a_rsp_needs_beat: assert property (p_rsp_needs_beat)
      else $error("result too soon after an input beat");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_red      (rsp_if.red),
   .rsp_green    (rsp_if.green),
   .rsp_blue     (rsp_if.blue),
   .rsp_frame_end(rsp_if.frame_end)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import bbd_pkg::*;

   localparam int          MAX_W           = DEFAULT_MAX_WIDTH;
   localparam int          RANDOM_BEATS    = 550;
   localparam int          SETTLE_CYCLES   = 10;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam longint      TIMEOUT_NS      = 64'd5_000_000;

   typedef struct packed {
      logic [PIXEL_W-1:0] raw_pixel;
      logic               pad;
   } raw_beat_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] blue;
      logic               frame_end;
   } rgb_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_data;

   bbd_req_if req_bus ();
   bbd_rsp_if rsp_bus ();

   bayer_bilinear_demosaic u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // demosaic predictor state
   logic [CFG_W-1:0]   cfg_width;
   logic [CFG_W-1:0]   cfg_height;
   logic               cfg_green_first;
   logic [PIXEL_W-1:0] line_mem [2*MAX_W];
   logic [PIXEL_W-1:0] win [9];
   int unsigned        in_col;
   int unsigned        in_row_cnt;
   int unsigned        out_col;
   int unsigned        out_row_cnt;

   raw_beat_type  pending_beats [$];
   rgb_pixel_type expected_pixels [$];
   int unsigned beats_queued   = 0;
   int unsigned beats_accepted = 0;
   int unsigned pixels_checked = 0;
   int unsigned csr_writes     = 0;
   int unsigned error_count    = 0;
   logic        hold_off_armed;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(input int unsigned value,
                                              input int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic logic [PIXEL_W-1:0] floor_mean(
         input logic [PIXEL_W-1:0] a, input logic va,
         input logic [PIXEL_W-1:0] b, input logic vb,
         input logic [PIXEL_W-1:0] c, input logic vc,
         input logic [PIXEL_W-1:0] d, input logic vd);
      int unsigned total;
      int unsigned count;
      total = 0;
      count = 0;
      if (va) begin total += 32'(a); count++; end
      if (vb) begin total += 32'(b); count++; end
      if (vc) begin total += 32'(c); count++; end
      if (vd) begin total += 32'(d); count++; end
      return (count == 0) ? '0 : PIXEL_W'(total / count);
   endfunction

   function automatic void demosaic_beat(input raw_beat_type beat);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      logic [PIXEL_W-1:0] px_value;
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] horiz;
      logic [PIXEL_W-1:0] vert;
      logic [PIXEL_W-1:0] nbr_mean;
      logic [PIXEL_W-1:0] diag_mean;
      logic               emit;
      logic               up;
      logic               dn;
      logic               lf;
      logic               rt;
      logic               row_even;
      logic               odd_col;
      colour_type         site;
      rgb_pixel_type      px;

      w = clamp_size(32'(cfg_width), MAX_W);
      h = clamp_size(32'(cfg_height), HEIGHT_LIMIT);
      px_value = beat.pad ? '0 : beat.raw_pixel;

      if (in_col >= w) begin
         in_col = 0;
         if (in_row_cnt < IN_ROW_MAX) in_row_cnt++;
      end
      c = (in_col >= MAX_W) ? 0 : in_col;

      top = line_mem[MAX_W + c];
      mid = line_mem[c];
      line_mem[MAX_W + c] = mid;
      line_mem[c] = px_value;

      for (int k = 0; k < 3; k++) begin
         win[3*k]   = win[3*k+1];
         win[3*k+1] = win[3*k+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px_value;

      emit = (in_row_cnt >= 2) || (in_row_cnt == 1 && in_col >= 1);

      if (in_col + 1 >= w) begin
         in_col = 0;
         if (in_row_cnt < IN_ROW_MAX) in_row_cnt++;
      end else begin
         in_col++;
      end

      if (!emit) return;

      up = out_row_cnt > 0;
      dn = out_row_cnt + 1 < h;
      lf = out_col > 0;
      rt = out_col + 1 < w;

      horiz     = floor_mean(win[3], lf, win[5], rt, '0, 1'b0, '0, 1'b0);
      vert      = floor_mean(win[1], up, win[7], dn, '0, 1'b0, '0, 1'b0);
      nbr_mean  = floor_mean(win[1], up, win[7], dn, win[3], lf, win[5], rt);
      diag_mean = floor_mean(win[0], up && lf, win[2], up && rt,
                             win[6], dn && lf, win[8], dn && rt);

      row_even = (out_row_cnt[0] == 1'b0);
      odd_col  = out_col[0] ^ cfg_green_first;
      if (row_even) site = odd_col ? SITE_GREEN : SITE_RED;
      else site = odd_col ? SITE_BLUE : SITE_GREEN;

      case (site)
         SITE_GREEN: begin
            px.green = win[4];
            px.red   = row_even ? horiz : vert;
            px.blue  = row_even ? vert : horiz;
         end
         SITE_RED: begin
            px.red   = win[4];
            px.green = nbr_mean;
            px.blue  = diag_mean;
         end
         default: begin
            px.blue  = win[4];
            px.green = nbr_mean;
            px.red   = diag_mean;
         end
      endcase

      px.frame_end = (out_row_cnt + 1 >= h) && (out_col + 1 >= w);
      if (px.frame_end) begin
         in_col = 0;
         in_row_cnt = 0;
         out_col = 0;
         out_row_cnt = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row_cnt++;
      end else begin
         out_col++;
      end

      expected_pixels.push_back(px);
   endfunction

   function automatic void push_beat(input logic [PIXEL_W-1:0] value, input logic is_pad);
      raw_beat_type beat;
      beat.raw_pixel = value;
      beat.pad = is_pad;
      pending_beats.push_back(beat);
      beats_queued++;
   endfunction

   function automatic logic [PIXEL_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // noise percent: pads inside the frame and pixels inside the drain
   function automatic void queue_frame(input int unsigned w, input int unsigned h,
                                       input int unsigned noise);
      for (int unsigned i = 0; i < w * h; i++)
         push_beat(random_sample(), $urandom_range(0, 99) < noise);
      for (int unsigned i = 0; i <= w; i++)
         push_beat(random_sample(), $urandom_range(0, 99) >= noise);
   endfunction

   task automatic program_geometry(input int unsigned w, input int unsigned h,
                                   input logic gf);
      cfg_width = CFG_W'(w);
      cfg_height = CFG_W'(h);
      cfg_green_first = gf;
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data  <= CFG_W'(w);
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data  <= CFG_W'(h);
      @(posedge clock);
      csr_index <= CSR_GREEN_FIRST;
      csr_data  <= CFG_W'(gf);
      @(posedge clock);
      csr_write <= 1'b0;
      csr_writes += 3;
   endtask

   task automatic settle_block();
      while (beats_accepted != beats_queued) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : driver
      raw_beat_type beat;
      int unsigned  burst_left;
      int unsigned  gap_left;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            beat.raw_pixel = req_bus.raw_pixel;
            beat.pad = req_bus.pad;
            demosaic_beat(beat);
            beats_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               beat = pending_beats.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.raw_pixel <= beat.raw_pixel;
               req_bus.pad       <= beat.pad;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                           : $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      int unsigned stall_cycle;
      int unsigned stall_mode;
      int unsigned hold_off_left;
      logic        hold_off_done;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cycle = 0;
         stall_mode = 0;
         hold_off_left = 0;
         hold_off_done = 1'b0;
      end else begin
         stall_cycle++;
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_off_armed && !hold_off_done) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (stall_cycle % 4 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   function automatic void compare_field(input string field, input logic [PIXEL_W-1:0] want,
                                         input logic [PIXEL_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch on pixel %0d: expected %0d, got %0d",
                field, pixels_checked, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rgb_pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel beat: red %0d green %0d blue %0d frame_end %0d",
                   rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.frame_end);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("red", want.red, rsp_bus.red);
            compare_field("green", want.green, rsp_bus.green);
            compare_field("blue", want.blue, rsp_bus.blue);
            compare_field("frame_end", PIXEL_W'(want.frame_end), PIXEL_W'(rsp_bus.frame_end));
            pixels_checked++;
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $error("timeout: %0d of %0d beats accepted, %0d pixels still expected",
             beats_accepted, beats_queued, expected_pixels.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned w;
      int unsigned h;
      int unsigned random_start;
      int unsigned style;
      logic        gf;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.raw_pixel = '0;
      req_bus.pad = 1'b0;
      rsp_bus.ready = 1'b0;
      hold_off_armed = 1'b0;
      cfg_width = CFG_W'(WIDTH_RESET);
      cfg_height = CFG_W'(HEIGHT_RESET);
      cfg_green_first = 1'b0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row_cnt = 0;
      out_col = 0;
      out_row_cnt = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // rggb 3x2 with extreme samples
      program_geometry(3, 2, 1'b0);
      push_beat(8'd255, 1'b0);
      push_beat(8'd0, 1'b0);
      push_beat(8'd255, 1'b0);
      push_beat(8'd0, 1'b0);
      push_beat(8'd255, 1'b0);
      push_beat(8'd0, 1'b0);
      for (int i = 0; i < 4; i++) push_beat(8'd0, 1'b1);
      settle_block();

      // grbg 2x2, pad inside the frame, pixel inside the drain
      program_geometry(2, 2, 1'b1);
      push_beat(8'd10, 1'b0);
      push_beat(8'd200, 1'b1);
      push_beat(8'd255, 1'b0);
      push_beat(8'd7, 1'b0);
      push_beat(8'd0, 1'b1);
      push_beat(8'd99, 1'b0);
      push_beat(8'd0, 1'b1);
      settle_block();

      // zero width and height act as 1x1
      program_geometry(0, 0, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hAA, 1'b1);
      push_beat(8'h55, 1'b1);
      settle_block();

      random_start = beats_queued;
      while (beats_queued - random_start < RANDOM_BEATS) begin
         if (beats_queued == random_start) begin
            w = 16;
            h = 6;
         end else begin
            case ($urandom_range(0, 9))
               0:       w = 0;
               1:       w = $urandom_range(20, 40);
               default: w = $urandom_range(1, 10);
            endcase
            h = $urandom_range(0, 5);
         end
         gf = 1'($urandom_range(0, 1));
         program_geometry(w, h, gf);
         w = clamp_size(w, MAX_W);
         h = clamp_size(h, HEIGHT_LIMIT);
         style = $urandom_range(0, 19);
         if (beats_queued == random_start) begin
            // long receiver hold-off while the first frame streams in
            hold_off_armed <= 1'b1;
            queue_frame(w, h, 0);
         end else if (style < 15) begin
            queue_frame(w, h, 0);
         end else if (style < 18) begin
            queue_frame(w, h, 15);
         end else begin
            // cut-off frame, next geometry lands mid-frame
            for (int unsigned i = $urandom_range(1, w * h); i != 0; i--)
               push_beat(random_sample(), 1'b0);
         end
         settle_block();
      end

      while (beats_accepted != beats_queued) @(posedge clock);
      for (int i = 0; i < 5000 && expected_pixels.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", expected_pixels.size());
         error_count += expected_pixels.size();
      end

      $display("%0d raw beats (%0d random), %0d rgb pixels checked, %0d register writes",
               beats_accepted, beats_queued - random_start, pixels_checked, csr_writes);
      $display("frames from 1x1 to 40 wide, zero geometry, both bayer phases, pads, cut frames");
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
